// ===== src/rank_then_two_stack_radix_sort_macros.svh =====
// assertion macros for the rank then radix sort block
`ifndef RANK_THEN_TWO_STACK_RADIX_SORT_MACROS_SVH
`define RANK_THEN_TWO_STACK_RADIX_SORT_MACROS_SVH
`ifndef SYNTH
`define RTS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RTS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RTS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RTS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/rtsrs_pkg.sv =====
// shared types and constants for the rank then radix sort block
`default_nettype none
package rtsrs_pkg;
   localparam int IDX_W = 6;
   localparam int CNT_W = 7;
   localparam int VAL_W = 32;

   typedef struct packed {
      logic             val_we;
      logic [IDX_W-1:0] val_waddr;
      logic [VAL_W-1:0] val_wdata;
      logic [IDX_W-1:0] val_raddr;
      logic             rank_we;
      logic [IDX_W-1:0] rank_waddr;
      logic [IDX_W-1:0] rank_wdata;
      logic [IDX_W-1:0] rank_raddr;
      logic             slot_we;
      logic [IDX_W-1:0] slot_waddr;
      logic [IDX_W-1:0] slot_wdata;
      logic [IDX_W-1:0] slot_raddr;
   } mem_req_type;

   typedef struct packed {
      logic [VAL_W-1:0] val_rdata;
      logic [IDX_W-1:0] rank_rdata;
      logic [IDX_W-1:0] slot_rdata;
   } mem_rsp_type;
endpackage
`default_nettype wire

// ===== src/rtsrs_store.sv =====
// value, rank and sorted slot memories with registered reads
`default_nettype none
module rtsrs_store
   import rtsrs_pkg::*;
#(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic        clock,
   input  wire mem_req_type mem_req,
   output mem_rsp_type      mem_rsp
);
   logic [VAL_W-1:0] val_mem  [MAX_ITEMS];
   logic [IDX_W-1:0] rank_mem [MAX_ITEMS];
   logic [IDX_W-1:0] slot_mem [MAX_ITEMS];

   always_ff @(posedge clock) begin
      if (mem_req.val_we) begin
         val_mem[mem_req.val_waddr] <= mem_req.val_wdata;
      end
      if (mem_req.rank_we) begin
         rank_mem[mem_req.rank_waddr] <= mem_req.rank_wdata;
      end
      if (mem_req.slot_we) begin
         slot_mem[mem_req.slot_waddr] <= mem_req.slot_wdata;
      end
      mem_rsp.val_rdata  <= val_mem[mem_req.val_raddr];
      mem_rsp.rank_rdata <= rank_mem[mem_req.rank_raddr];
      mem_rsp.slot_rdata <= slot_mem[mem_req.slot_raddr];
   end
endmodule
`default_nettype wire

// ===== src/rtsrs_ctrl.sv =====
// load, rank sweep and output sequencer
`default_nettype none
`include "rank_then_two_stack_radix_sort_macros.svh"
module rtsrs_ctrl
   import rtsrs_pkg::*;
#(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [VAL_W-1:0] req_sample,
   input  wire logic             req_final,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [VAL_W-1:0]      rsp_value,
   output logic [IDX_W-1:0]      rsp_rank,
   output logic                  rsp_last,
   output mem_req_type           mem_req,
   input  wire mem_rsp_type      mem_rsp
);
   typedef enum logic [7:0] {
      S_LOAD  = 8'b0000_0001,
      S_FETCH = 8'b0000_0010,
      S_HOLD  = 8'b0000_0100,
      S_SWEEP = 8'b0000_1000,
      S_OREAD = 8'b0001_0000,
      S_OSEL  = 8'b0010_0000,
      S_OWAIT = 8'b0100_0000,
      S_OHOLD = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [IDX_W-1:0]   d_ff, d_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   lt_ff, lt_in;
   logic [CNT_W-1:0]   eq_ff, eq_in;
   logic [VAL_W-1:0]   vi_ff, vi_in;
   logic               valid_ff, valid_in;
   logic [VAL_W-1:0]   value_ff, value_in;
   logic [IDX_W-1:0]   rank_ff, rank_in;
   logic               last_ff, last_in;

   logic               req_acc, rsp_acc, room;
   logic               lt_hit, eq_hit, last_d;
   logic [CNT_W-1:0]   lt_sum, eq_sum, pos;

   assign req_tready = (state_ff == S_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_acc    = valid_ff && rsp_tready;
   assign rsp_value  = value_ff;
   assign rsp_rank   = rank_ff;
   assign rsp_last   = last_ff;
   assign room       = (cnt_ff < CNT_W'(MAX_ITEMS));

   assign lt_hit = ($signed(mem_rsp.val_rdata) < $signed(vi_ff));
   assign eq_hit = (mem_rsp.val_rdata == vi_ff) && (d_ff < i_ff);
   assign lt_sum = lt_ff + CNT_W'(lt_hit);
   assign eq_sum = eq_ff + CNT_W'(eq_hit);
   assign pos    = lt_sum + eq_sum;
   assign last_d = (({1'b0, d_ff} + CNT_W'(1)) == cnt_ff);

   always_comb begin
      mem_req            = '0;
      mem_req.val_waddr  = cnt_ff[IDX_W-1:0];
      mem_req.val_wdata  = req_sample;
      mem_req.val_we     = req_acc && room;
      mem_req.rank_waddr = i_ff;
      mem_req.rank_wdata = lt_sum[IDX_W-1:0];
      mem_req.rank_raddr = mem_rsp.slot_rdata;
      mem_req.slot_waddr = pos[IDX_W-1:0];
      mem_req.slot_wdata = i_ff;
      mem_req.slot_raddr = j_ff;
      mem_req.rank_we    = (state_ff == S_SWEEP) && last_d;
      mem_req.slot_we    = (state_ff == S_SWEEP) && last_d;
      unique case (state_ff)
         S_FETCH: mem_req.val_raddr = i_ff;
         S_SWEEP: mem_req.val_raddr = d_ff + IDX_W'(1);
         S_OSEL:  mem_req.val_raddr = mem_rsp.slot_rdata;
         default: mem_req.val_raddr = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      i_in     = i_ff;
      d_in     = d_ff;
      j_in     = j_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      vi_in    = vi_ff;
      valid_in = valid_ff;
      value_in = value_ff;
      rank_in  = rank_ff;
      last_in  = last_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (room) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (req_final) begin
                  i_in     = '0;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: state_in = S_HOLD;
         S_HOLD: begin
            vi_in    = mem_rsp.val_rdata;
            d_in     = '0;
            lt_in    = '0;
            eq_in    = '0;
            state_in = S_SWEEP;
         end
         S_SWEEP: begin
            if (last_d) begin
               if (({1'b0, i_ff} + CNT_W'(1)) == cnt_ff) begin
                  j_in     = '0;
                  state_in = S_OREAD;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = S_FETCH;
               end
            end else begin
               lt_in = lt_sum;
               eq_in = eq_sum;
               d_in  = d_ff + IDX_W'(1);
            end
         end
         S_OREAD: state_in = S_OSEL;
         S_OSEL:  state_in = S_OWAIT;
         S_OWAIT: begin
            value_in = mem_rsp.val_rdata;
            rank_in  = mem_rsp.rank_rdata;
            last_in  = (({1'b0, j_ff} + CNT_W'(1)) == cnt_ff);
            valid_in = 1'b1;
            state_in = S_OHOLD;
         end
         S_OHOLD: begin
            if (rsp_acc) begin
               valid_in = 1'b0;
               if (last_ff) begin
                  cnt_in   = '0;
                  state_in = S_LOAD;
               end else begin
                  j_in     = j_ff + IDX_W'(1);
                  state_in = S_OREAD;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
      i_ff     <= i_in;
      d_ff     <= d_in;
      j_ff     <= j_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
      vi_ff    <= vi_in;
      value_ff <= value_in;
      rank_ff  <= rank_in;
      last_ff  <= last_in;
   end

   `RTS_ASSERT_IMP(a_valid_in_hold, clock, reset, valid_ff, state_ff == S_OHOLD)
   `RTS_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_ITEMS))
   `RTS_ASSERT_NXT(a_last_clears, clock, reset, rsp_acc && last_ff, cnt_ff == '0)
   `RTS_ASSERT_IMP(a_sweep_nonempty, clock, reset, state_ff == S_SWEEP, cnt_ff != '0)
endmodule
`default_nettype wire

// ===== src/rank_then_two_stack_radix_sort.sv =====
// top level of the rank then radix sort block
// loading takes one cycle per item; the final item starts the sort
// ranking sweeps the value memory once per element
// output reads slot then value and rank memories for each item and holds each item until it is taken
// reset is synchronous and active high, it empties the set; memories are not cleared
`default_nettype none
module rank_then_two_stack_radix_sort
   import rtsrs_pkg::*;
#(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // sample[31:0]
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // sorted_value[31:0], value_rank[37:32], zero
   output logic             rsp_tlast
);
   mem_req_type      mem_req;
   mem_rsp_type      mem_rsp;
   logic [VAL_W-1:0] rsp_value;
   logic [IDX_W-1:0] rsp_rank;

   rtsrs_store #(.MAX_ITEMS(MAX_ITEMS)) u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   rtsrs_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_sample (req_tdata),
      .req_final  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_rank   (rsp_rank),
      .rsp_last   (rsp_tlast),
      .mem_req    (mem_req),
      .mem_rsp    (mem_rsp)
   );

   assign rsp_tdata = {2'b00, rsp_rank, rsp_value};
endmodule
`default_nettype wire
